// File: hw/rtl/uartbd_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor package
// Shared widths, codes and transfer types for the divisor calculator.
// ----------------------------------------------------------------------------
package uartbd_pkg;

   localparam int ClkWidth  = 27;
   localparam int BaudWidth = 24;
   localparam int PreWidth  = 9;
   localparam int DenWidth  = BaudWidth + PreWidth;
   localparam int CntWidth  = $clog2(ClkWidth);

   localparam logic [ClkWidth-1:0]  ClkReset  = ClkWidth'(26000000);
   localparam logic [BaudWidth-1:0] BaudLimit = BaudWidth'(115200);

   localparam logic [1:0] MODE_OVERSAMPLE   = 2'd0;
   localparam logic [1:0] MODE_SAMPLE_COUNT = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic                 mode3;
      logic [BaudWidth-1:0] baud;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  speed_mode;
      logic [7:0]  divisor_low;
      logic [7:0]  divisor_high;
      logic [15:0] sample_cnt;
      logic [15:0] sample_pos;
      logic        divisor_overflow;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV1,
      ST_MUL,
      ST_DIV2
   } back_state_type;

endpackage

// File: hw/rtl/uartbd_front.sv
// ----------------------------------------------------------------------------
// UART baud divisor front end
// Accepts requests, classifies the speed mode and queues them (2 deep).
// ----------------------------------------------------------------------------
module uartbd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [uartbd_pkg::BaudWidth-1:0]  baud,
   input  logic                              pop,
   output logic                              busy,
   output uartbd_pkg::item_type              head
);

   logic                             mode3_ff [2];
   logic [uartbd_pkg::BaudWidth-1:0] baud_ff  [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         baud_ff[wr_ptr_ff]  <= baud;
         mode3_ff[wr_ptr_ff] <= (baud > uartbd_pkg::BaudLimit);
      end
   end

   always_comb begin
      head.valid = (count_ff != 2'd0);
      head.mode3 = mode3_ff[rd_ptr_ff];
      head.baud  = baud_ff[rd_ptr_ff];
   end

endmodule

// File: hw/rtl/uartbd_back.sv
// ----------------------------------------------------------------------------
// UART baud divisor back end
// Shared restoring divider, prescaler multiply and result formatting.
// ----------------------------------------------------------------------------
module uartbd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [uartbd_pkg::ClkWidth-1:0]  clk_hz,
   input  uartbd_pkg::item_type             head,
   output logic                             pop,
   output uartbd_pkg::result_type           result
);

   localparam int CW = uartbd_pkg::ClkWidth;
   localparam int DW = uartbd_pkg::DenWidth;
   localparam int BW = uartbd_pkg::BaudWidth;
   localparam int PW = uartbd_pkg::PreWidth;
   localparam int NW = uartbd_pkg::CntWidth;

   uartbd_pkg::back_state_type state_ff, state_in;
   uartbd_pkg::result_type     result_ff, result_in;

   logic [BW-1:0] baud_ff, baud_in;
   logic          mode3_ff, mode3_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] quo_ff, quo_in;
   logic [CW-1:0] dvd_ff, dvd_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] pre_ff, pre_in;

   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW-1:0] rem_nx;
   logic [CW-1:0] quo_nx;
   logic          last;
   logic          round_up;
   logic [CW:0]   div_full;
   logic [15:0]   scount;

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[CW-1]};
      ge       = (rem_sh >= {1'b0, den_ff});
      rem_nx   = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
      quo_nx   = {quo_ff[CW-2:0], ge};
      last     = (cnt_ff == NW'(CW - 1));
      round_up = (rem_nx >= (den_ff >> 1));
      div_full = {1'b0, quo_nx} + {{CW{1'b0}}, round_up};
      scount   = div_full[15:0] - 16'd1;
   end

   always_comb begin
      state_in  = state_ff;
      baud_in   = baud_ff;
      mode3_in  = mode3_ff;
      den_in    = den_ff;
      rem_in    = rem_nx;
      quo_in    = quo_nx;
      dvd_in    = {dvd_ff[CW-2:0], 1'b0};
      cnt_in    = cnt_ff + NW'(1);
      pre_in    = pre_ff;
      result_in = '0;
      pop       = 1'b0;
      case (state_ff)
         uartbd_pkg::ST_IDLE: begin
            rem_in = '0;
            quo_in = '0;
            dvd_in = clk_hz;
            cnt_in = '0;
            if (head.valid) begin
               pop      = 1'b1;
               baud_in  = head.baud;
               mode3_in = head.mode3;
               if (head.mode3) begin
                  den_in   = DW'(head.baud);
                  state_in = uartbd_pkg::ST_DIV1;
               end else if (head.baud == '0) begin
                  result_in.valid            = 1'b1;
                  result_in.speed_mode       = uartbd_pkg::MODE_OVERSAMPLE;
                  result_in.divisor_low      = 8'hFF;
                  result_in.divisor_high     = 8'hFF;
                  result_in.divisor_overflow = 1'b1;
               end else begin
                  den_in   = DW'({head.baud, 4'b0000});
                  state_in = uartbd_pkg::ST_DIV2;
               end
            end
         end
         uartbd_pkg::ST_DIV1: begin
            if (last) begin
               pre_in   = {1'b0, quo_nx[15:8]} + PW'(1);
               state_in = uartbd_pkg::ST_MUL;
            end
         end
         uartbd_pkg::ST_MUL: begin
            den_in   = DW'(baud_ff) * DW'(pre_ff);
            rem_in   = '0;
            quo_in   = '0;
            dvd_in   = clk_hz;
            cnt_in   = '0;
            state_in = uartbd_pkg::ST_DIV2;
         end
         uartbd_pkg::ST_DIV2: begin
            if (last) begin
               state_in        = uartbd_pkg::ST_IDLE;
               result_in.valid = 1'b1;
               if (mode3_ff) begin
                  result_in.speed_mode   = uartbd_pkg::MODE_SAMPLE_COUNT;
                  result_in.divisor_low  = pre_ff[7:0];
                  result_in.divisor_high = {7'd0, pre_ff[8]};
                  result_in.sample_cnt   = scount;
                  result_in.sample_pos   = 16'(scount - 16'd1) >> 1;
               end else begin
                  result_in.speed_mode       = uartbd_pkg::MODE_OVERSAMPLE;
                  result_in.divisor_low      = div_full[7:0];
                  result_in.divisor_high     = div_full[15:8];
                  result_in.divisor_overflow = (div_full[CW:16] != '0);
               end
            end
         end
         default: state_in = uartbd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= uartbd_pkg::ST_IDLE;
         result_ff <= '0;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      baud_ff  <= baud_in;
      mode3_ff <= mode3_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvd_ff   <= dvd_in;
      cnt_ff   <= cnt_in;
      pre_ff   <= pre_in;
   end

   assign result = result_ff;

endmodule

// File: hw/rtl/uart_baud_divisor_calc_core.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator
// Mode 0 runs one division; mode 3 runs a division, a prescaler multiply and a
// second division; zero baud is answered from idle. Requests are served one at a
// time by the shared one-bit-per-cycle divider; a 2-entry queue takes requests meanwhile.
// Responses are one-cycle strobes; the receiver cannot stall them.
// Reset: synchronous; clears the queue and sets the source clock to 26 MHz.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_baud_rate,
   output logic        rsp_valid,
   output logic [1:0]  rsp_speed_mode,
   output logic [7:0]  rsp_divisor_low,
   output logic [7:0]  rsp_divisor_high,
   output logic [15:0] rsp_sample_cnt,
   output logic [15:0] rsp_sample_pos,
   output logic        rsp_divisor_overflow,
   input  logic        csr_write_enable,
   input  logic [26:0] csr_write_data
);

   logic [uartbd_pkg::ClkWidth-1:0] clk_hz_ff;
   uartbd_pkg::item_type            head;
   uartbd_pkg::result_type          result;
   logic                            pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= uartbd_pkg::ClkReset;
      end else if (csr_write_enable) begin
         clk_hz_ff <= csr_write_data;
      end
   end

   uartbd_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .baud  (req_baud_rate),
      .pop   (pop),
      .busy  (busy),
      .head  (head)
   );

   uartbd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .clk_hz (clk_hz_ff),
      .head   (head),
      .pop    (pop),
      .result (result)
   );

   assign rsp_valid            = result.valid;
   assign rsp_speed_mode       = result.speed_mode;
   assign rsp_divisor_low      = result.divisor_low;
   assign rsp_divisor_high     = result.divisor_high;
   assign rsp_sample_cnt       = result.sample_cnt;
   assign rsp_sample_pos       = result.sample_pos;
   assign rsp_divisor_overflow = result.divisor_overflow;

   a_ovf_mode0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor_overflow |-> rsp_speed_mode == uartbd_pkg::MODE_OVERSAMPLE)
      else $error("overflow flagged outside mode 0");

   a_mode0_no_sc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_mode == uartbd_pkg::MODE_OVERSAMPLE
         |-> rsp_sample_cnt == 16'd0 && rsp_sample_pos == 16'd0)
      else $error("sample fields set in mode 0");

   a_prescaler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_mode == uartbd_pkg::MODE_SAMPLE_COUNT
         |-> rsp_divisor_high == 8'd0 || (rsp_divisor_high == 8'd1 && rsp_divisor_low == 8'd0))
      else $error("prescaler out of range");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

// File: dv/uart_baud_divisor_calc_checker.sv
// ----------------------------------------------------------------------------
// UART baud divisor checker
// Watches request and response transfers, predicts the divisor fields from
// the current source clock setting and compares each response in order.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [23:0]          req_baud_rate,
   input  logic                 rsp_valid,
   input  logic [1:0]           rsp_speed_mode,
   input  logic [7:0]           rsp_divisor_low,
   input  logic [7:0]           rsp_divisor_high,
   input  logic [15:0]          rsp_sample_cnt,
   input  logic [15:0]          rsp_sample_pos,
   input  logic                 rsp_divisor_overflow,
   input  logic                 csr_write_enable,
   input  logic [26:0]          csr_write_data,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  speed_mode;
      logic [7:0]  divisor_low;
      logic [7:0]  divisor_high;
      logic [15:0] sample_cnt;
      logic [15:0] sample_pos;
      logic        divisor_overflow;
   } divisor_fields_type;

   logic [uartbd_pkg::ClkWidth-1:0] source_clock;
   divisor_fields_type              expected_divisors[$];

   function automatic divisor_fields_type compute_divisors(logic [26:0] clk_hz,
                                                           logic [23:0] baud);
      divisor_fields_type f;
      longint unsigned c, b, d, den, ratio, pre;
      c = clk_hz;
      b = baud;
      f = '0;
      if (b <= 115200) begin
         f.speed_mode = uartbd_pkg::MODE_OVERSAMPLE;
         if (b == 0) begin
            d = 64'hFFFF;
            f.divisor_overflow = 1'b1;
         end else begin
            den = 16 * b;
            d = c / den;
            if (c % den >= 8 * b) d++;
            if (d > 64'hFFFF) f.divisor_overflow = 1'b1;
         end
         f.divisor_low  = d[7:0];
         f.divisor_high = d[15:8];
      end else begin
         f.speed_mode = uartbd_pkg::MODE_SAMPLE_COUNT;
         ratio = (c / b) & 64'hFFFF;
         pre = (ratio >> 8) + 1;
         den = b * pre;
         d = c / den;
         if (c % den >= (den >> 1)) d++;
         f.sample_cnt   = 16'(d - 1);
         f.sample_pos   = 16'(f.sample_cnt - 16'd1) >> 1;
         f.divisor_low  = pre[7:0];
         f.divisor_high = pre[15:8];
      end
      return f;
   endfunction

   always @(posedge clock) begin
      divisor_fields_type got, want;
      if (reset) begin
         source_clock <= uartbd_pkg::ClkReset;
         expected_divisors.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_speed_mode, rsp_divisor_low, rsp_divisor_high,
                   rsp_sample_cnt, rsp_sample_pos, rsp_divisor_overflow};
            if (expected_divisors.size() == 0) begin
               if (fail_count < 10) $display("ERROR: unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_divisors.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("ERROR: mode %0d/%0d lo %h/%h hi %h/%h cnt %h/%h pt %h/%h ovf %b/%b",
                              want.speed_mode, got.speed_mode,
                              want.divisor_low, got.divisor_low,
                              want.divisor_high, got.divisor_high,
                              want.sample_cnt, got.sample_cnt,
                              want.sample_pos, got.sample_pos,
                              want.divisor_overflow, got.divisor_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_divisors.push_back(compute_divisors(source_clock, req_baud_rate));
         if (csr_write_enable) source_clock <= csr_write_data;
      end
      pending_count = expected_divisors.size();
   end
endmodule

// File: dv/tb_uart_baud_divisor_calc_core.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator testbench
// Directed corner rates, then random rates over several source clocks,
// with random request gaps; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_uart_baud_divisor_calc_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [23:0] req_baud_rate = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_speed_mode;
   logic [7:0]  rsp_divisor_low, rsp_divisor_high;
   logic [15:0] rsp_sample_cnt, rsp_sample_pos;
   logic        rsp_divisor_overflow;
   logic        csr_write_enable = 1'b0;
   logic [26:0] csr_write_data = '0;
   int          fail_count, pending_count;

   always #1 clock = ~clock;

   uart_baud_divisor_calc_core dut (.*);
   uart_baud_divisor_calc_checker checker_i (.*);

   task automatic send_rate(logic [23:0] baud);
      int gap;
      start <= 1'b1;
      req_baud_rate <= baud;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      gap = 0;
      if ($urandom_range(9) < 7) begin
         if ($urandom_range(9) == 0) gap = int'($urandom_range(200, 40));
         else gap = int'($urandom_range(3));
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   task automatic set_clock(logic [26:0] hz);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= hz;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [23:0] random_rate;
      case ($urandom_range(5))
         0: return 24'($urandom_range(115200, 1));
         1: return 24'($urandom_range(115300, 115100));
         2: return 24'($urandom_range(16000000, 115201));
         3: return 24'($urandom_range(2000, 1));
         4: return 24'($urandom);
         default: return 24'($urandom_range(4000000, 115201));
      endcase
   endfunction

   initial begin
      logic [26:0] clocks[6];
      logic [23:0] corners[8];
      clocks = '{27'd1000000, 27'd100000000, 27'd26000000, 27'd0, 27'd3, 27'h7FFFFFF};
      corners = '{24'd0, 24'd1, 24'd2, 24'd115199, 24'd115200, 24'd115201,
                  24'd16000000, 24'hFFFFFF};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (clocks[i]) begin
         set_clock(clocks[i]);
         foreach (corners[j]) send_rate(corners[j]);
      end
      send_rate(24'd9600);
      for (int k = 0; k < 1800; k++) begin
         if (k % 300 == 0) begin
            if ($urandom_range(1)) set_clock(27'($urandom_range(100000000, 1000000)));
            else set_clock(27'($urandom));
         end
         send_rate(random_rate());
      end
      drain();
      if (fail_count == 0) $display("** uart_baud_divisor_calc_core: PASSED **");
      else $display("** uart_baud_divisor_calc_core: FAILED **");
      $finish;
   end

   initial begin
      #5000000;
      $display("** uart_baud_divisor_calc_core: FAILED **");
      $finish;
   end
endmodule

// File: uart_baud_divisor_calc_core.f
hw/rtl/uartbd_pkg.sv
hw/rtl/uartbd_front.sv
hw/rtl/uartbd_back.sv
hw/rtl/uart_baud_divisor_calc_core.sv
dv/uart_baud_divisor_calc_checker.sv
dv/tb_uart_baud_divisor_calc_core.sv
